// ----- rtl/potl_pkg.sv -----
`timescale 1ns / 1ps

package potl_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int PTR_W     = $clog2(SLOTS + 1);
    localparam int TIME_BITS = 32;
    localparam int FUNC_W    = 3;
    localparam int CNT_W     = $clog2(SLOTS + 1);

    localparam logic [PTR_W-1:0] NONE_SLOT = PTR_W'(SLOTS);

    // input and output tdata widths
    localparam int IN_W  = 72;
    localparam int OUT_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_PLAY    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REG     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNREG   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REARM   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_LINK,
        ST_SEARCH,
        ST_PLAY,
        ST_FINISH,
        ST_RESP
    } t_state;

endpackage

// ----- rtl/periodic_oneshot_timer_list_unit.sv -----
`timescale 1ns / 1ps

// Timer list: a table of timer slots, the registered ones linked in
// registration order.
// Input channel s_axis carries one command per transfer (play, set, register,
// unregister, rearm, query). Output channel m_axis carries result items; tlast
// marks the final result of a command.
// s_axis_tready is high only while the sequencer is idle: one command is
// worked on at a time.
// Set, rearm and query go from op to result; a new register adds a link step.
// Unregister of a registered slot that is not the head walks the list from
// the head, one link per cycle.
// Play walks the linked slots one per cycle, save while the receiver stalls,
// through a single subtract and compare unit (elapsed time against the period);
// each fired slot gives one result.
// The next command can transfer at the same edge as the last result.
// Reset empties the list and clears all registration flags; period, start
// time and mode of a slot hold no defined value until set.
// When the receiver stalls, the result register holds its transfer and the
// walk pauses at the next fired slot until the register frees up.

module periodic_oneshot_timer_list_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // func[2:0], slot[6:3], period[38:7], one_shot[39], now[71:40]
    input  logic [potl_pkg::IN_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // fired[0], fired_slot[4:1], is_registered[5], zero pad[7:6]
    output logic [potl_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);
    import potl_pkg::*;

    t_state r_state, n_state;

    // captured command
    logic [FUNC_W-1:0]    r_func;
    logic [SLOT_W-1:0]    r_slot;
    logic [TIME_BITS-1:0] r_period;
    logic                 r_once_in;
    logic [TIME_BITS-1:0] r_now;

    // list state
    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [PTR_W-1:0]     r_next [SLOTS];
    logic [SLOTS-1:0]     r_linked, n_linked;
    logic [TIME_BITS-1:0] r_slot_period [SLOTS];
    logic [TIME_BITS-1:0] r_slot_start [SLOTS];
    logic [SLOTS-1:0]     r_slot_once;

    // walk state
    logic [PTR_W-1:0]     r_cur, n_cur;
    logic [PTR_W-1:0]     r_prev, n_prev;
    logic [PTR_W-1:0]     r_p, n_p;
    logic [PTR_W-1:0]     r_nxt_s, n_nxt_s;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0]    r_pend_slot, n_pend_slot;
    logic                 r_pend_reg, n_pend_reg;

    // result register
    logic                 r_ovalid;
    logic                 r_ofired;
    logic [SLOT_W-1:0]    r_oslot;
    logic                 r_oreg;
    logic                 r_olast;

    logic                 s_accept;
    logic                 out_free;
    logic [SLOT_W-1:0]    rd_addr;
    logic [PTR_W-1:0]     rd_next;
    logic                 rd_once;
    logic [TIME_BITS-1:0] elapsed;
    logic                 due;
    logic                 cur_end;
    logic                 play_stall;
    logic                 play_go;
    logic                 play_done;

    logic                 next_we;
    logic [SLOT_W-1:0]    next_wa;
    logic [PTR_W-1:0]     next_wd;
    logic                 start_we;
    logic [TIME_BITS-1:0] start_wd;
    logic                 cfg_we;

    logic                 push;
    logic                 push_fired;
    logic [SLOT_W-1:0]    push_slot;
    logic                 push_reg;
    logic                 push_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    always_comb begin
        case (r_state)
            ST_PLAY:   rd_addr = r_cur[SLOT_W-1:0];
            ST_SEARCH: rd_addr = r_p[SLOT_W-1:0];
            default:   rd_addr = r_slot;
        endcase
    end

    assign rd_next = r_next[rd_addr];
    assign rd_once = r_slot_once[rd_addr];

    // shared compare unit: wrap-around elapsed time against the period
    assign elapsed = r_now - r_slot_start[rd_addr];
    assign due     = elapsed > r_slot_period[rd_addr];

    assign cur_end    = (r_cur >= NONE_SLOT) || (r_cnt == CNT_W'(SLOTS));
    assign play_stall = due && r_pend_valid && !out_free;
    assign play_go    = (r_state == ST_PLAY) && !cur_end && !play_stall;
    assign play_done  = (r_state == ST_PLAY) && cur_end;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tdata[FUNC_W-1:0] == FUNC_PLAY) begin
                        n_state = ST_PLAY;
                    end else begin
                        n_state = ST_OP;
                    end
                end
            end
            ST_OP: begin
                case (r_func)
                    FUNC_REG: begin
                        n_state = r_linked[r_slot] ? ST_RESP : ST_LINK;
                    end
                    FUNC_UNREG: begin
                        if (r_linked[r_slot] && (r_head != PTR_W'(r_slot))) begin
                            n_state = ST_SEARCH;
                        end else begin
                            n_state = ST_RESP;
                        end
                    end
                    default: n_state = ST_RESP;
                endcase
            end
            ST_LINK: n_state = ST_RESP;
            ST_SEARCH: begin
                if ((rd_next == PTR_W'(r_slot)) || (r_p >= NONE_SLOT)) begin
                    n_state = ST_RESP;
                end
            end
            ST_PLAY: begin
                if (play_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls and list updates
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_linked     = r_linked;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_p          = r_p;
        n_nxt_s      = r_nxt_s;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_reg   = r_pend_reg;
        next_we      = 1'b0;
        next_wa      = rd_addr;
        next_wd      = NONE_SLOT;
        start_we     = 1'b0;
        start_wd     = r_now;
        cfg_we       = 1'b0;
        push         = 1'b0;
        push_fired   = 1'b0;
        push_slot    = '0;
        push_reg     = 1'b0;
        push_last    = 1'b1;

        case (r_state)
            ST_IDLE: begin
                n_cur        = r_head;
                n_prev       = NONE_SLOT;
                n_cnt        = '0;
                n_pend_valid = 1'b0;
            end
            ST_OP: begin
                case (r_func)
                    FUNC_SET: begin
                        cfg_we   = 1'b1;
                        start_we = 1'b1;
                        start_wd = '0;
                    end
                    FUNC_REG: begin
                        if (!r_linked[r_slot]) begin
                            next_we          = 1'b1;
                            next_wa          = r_slot;
                            next_wd          = NONE_SLOT;
                            n_linked[r_slot] = 1'b1;
                            start_we         = 1'b1;
                        end
                    end
                    FUNC_UNREG: begin
                        if (r_linked[r_slot]) begin
                            n_linked[r_slot] = 1'b0;
                            if (r_head == PTR_W'(r_slot)) begin
                                n_head = rd_next;
                                if (rd_next == NONE_SLOT) begin
                                    n_tail = NONE_SLOT;
                                end
                            end else begin
                                n_p     = r_head;
                                n_nxt_s = rd_next;
                            end
                        end
                    end
                    FUNC_REARM: begin
                        start_we = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_LINK: begin
                // append at the tail
                if (r_head == NONE_SLOT) begin
                    n_head = PTR_W'(r_slot);
                end else begin
                    next_we = 1'b1;
                    next_wa = r_tail[SLOT_W-1:0];
                    next_wd = PTR_W'(r_slot);
                end
                n_tail = PTR_W'(r_slot);
            end
            ST_SEARCH: begin
                if (r_p < NONE_SLOT) begin
                    if (rd_next == PTR_W'(r_slot)) begin
                        // bypass the removed slot
                        next_we = 1'b1;
                        next_wa = r_p[SLOT_W-1:0];
                        next_wd = r_nxt_s;
                        if (r_tail == PTR_W'(r_slot)) begin
                            n_tail = r_p;
                        end
                    end else begin
                        n_p = rd_next;
                    end
                end
            end
            ST_PLAY: begin
                if (play_go) begin
                    n_cur = rd_next;
                    n_cnt = r_cnt + 1'b1;
                    if (due) begin
                        start_we     = 1'b1;
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_cur[SLOT_W-1:0];
                        n_pend_reg   = !rd_once;
                        // release the previous fire, more results follow
                        if (r_pend_valid) begin
                            push       = 1'b1;
                            push_fired = 1'b1;
                            push_slot  = r_pend_slot;
                            push_reg   = r_pend_reg;
                            push_last  = 1'b0;
                        end
                        if (rd_once) begin
                            n_linked[r_cur[SLOT_W-1:0]] = 1'b0;
                            if (r_head == r_cur) begin
                                n_head = rd_next;
                                if (rd_next == NONE_SLOT) begin
                                    n_tail = NONE_SLOT;
                                end
                            end else begin
                                next_we = 1'b1;
                                next_wa = r_prev[SLOT_W-1:0];
                                next_wd = rd_next;
                                if (r_tail == r_cur) begin
                                    n_tail = r_prev;
                                end
                            end
                        end else begin
                            n_prev = r_cur;
                        end
                    end else begin
                        n_prev = r_cur;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_fired = r_pend_valid;
                    push_slot  = r_pend_valid ? r_pend_slot : '0;
                    push_reg   = r_pend_valid && r_pend_reg;
                    push_last  = 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    push     = 1'b1;
                    push_reg = r_linked[r_slot];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= NONE_SLOT;
            r_tail   <= NONE_SLOT;
            r_linked <= '0;
            r_ovalid <= 1'b0;
            r_pend_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_next[i] <= NONE_SLOT;
            end
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_linked     <= n_linked;
            r_pend_valid <= n_pend_valid;
            if (next_we) begin
                r_next[next_wa] <= next_wd;
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func    <= s_axis_tdata[2:0];
            r_slot    <= s_axis_tdata[6:3];
            r_period  <= s_axis_tdata[38:7];
            r_once_in <= s_axis_tdata[39];
            r_now     <= s_axis_tdata[71:40];
        end
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_p         <= n_p;
        r_nxt_s     <= n_nxt_s;
        r_cnt       <= n_cnt;
        r_pend_slot <= n_pend_slot;
        r_pend_reg  <= n_pend_reg;
        if (cfg_we) begin
            r_slot_period[r_slot] <= r_period;
            r_slot_once[r_slot]   <= r_once_in;
        end
        if (start_we) begin
            r_slot_start[rd_addr] <= start_wd;
        end
        if (push) begin
            r_ofired <= push_fired;
            r_oslot  <= push_slot;
            r_oreg   <= push_reg;
            r_olast  <= push_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_oreg, r_oslot, r_ofired};
    assign m_axis_tlast  = r_olast;

    // an empty list has neither head nor tail
    a_head_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NONE_SLOT) == (r_tail == NONE_SLOT))
        else $error("head and tail disagree on an empty list");

    // the head is always a registered slot
    a_head_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != NONE_SLOT) |-> r_linked[r_head[SLOT_W-1:0]])
        else $error("head slot is not registered");

    // a result without a fire is always the final one of its command
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tlast)
        else $error("non-fire result not marked last");

    // fire results are only produced by a play
    a_fire_in_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && push_fired |-> (r_state == ST_PLAY || r_state == ST_FINISH))
        else $error("fire result outside a play");

    // the walk never visits more slots than exist
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PLAY) |-> (r_cnt <= CNT_W'(SLOTS)))
        else $error("play walk exceeded slot count");

endmodule
